FILE: hdl/apb_pkg.sv
// Shared constants and field widths for the alpha pattern blend unit.
package apb_pkg;

   localparam int COORD_W = 16;
   localparam int CHAN_W  = 8;
   localparam int RGB_W   = 3 * CHAN_W;
   localparam int OP_W    = 2;

   localparam logic [OP_W-1:0] OP_LOAD_RGB   = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_INDEX = 2'd1;
   localparam logic [OP_W-1:0] OP_BLEND      = 2'd2;

   localparam logic [CHAN_W-1:0] FULL_ALPHA = 8'd255;

   // Result queue behind the pipeline; deep enough to cover every beat in flight.
   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
   localparam int OUT_W     = 4 * CHAN_W;

   typedef logic [CHAN_W-1:0] chan_type;

endpackage

FILE: hdl/apb_mod.sv
// Two-stage pipelined remainder of a 16-bit coordinate by a constant divisor.
module apb_mod import apb_pkg::*; #(
   parameter int DIVISOR = 8
) (
   input  logic                       clock,
   input  logic [COORD_W-1:0]         value,
   output logic [$clog2(DIVISOR)-1:0] remainder
);

   localparam int REM_W    = $clog2(DIVISOR);
   localparam int SHIFT    = 22;
   localparam int RECIP_W  = 22;
   localparam int PROD_W   = COORD_W + RECIP_W;
   localparam int RECIP    = (2 ** SHIFT) / DIVISOR;

   localparam logic [RECIP_W-1:0] RECIP_VEC = RECIP_W'(RECIP);
   localparam logic [COORD_W-1:0] DIV_VEC   = COORD_W'(DIVISOR);

   logic [PROD_W-1:0]  prod_in, prod_ff;
   logic [COORD_W-1:0] value_ff;
   logic [COORD_W-1:0] quot;
   logic [COORD_W-1:0] rough;
   logic [REM_W-1:0]   rem_in, rem_ff;

   // The truncated reciprocal can leave the quotient one short, so the
   // rough remainder stays below twice the divisor and needs one correction.
   assign prod_in = PROD_W'(value) * PROD_W'(RECIP_VEC);
   assign quot    = prod_ff[PROD_W-1:SHIFT];
   assign rough   = value_ff - COORD_W'(quot * DIV_VEC);

   always_comb begin
      if (rough >= DIV_VEC) begin
         rem_in = REM_W'(rough - DIV_VEC);
      end else begin
         rem_in = REM_W'(rough);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      value_ff <= value;
      rem_ff   <= rem_in;
   end

   assign remainder = rem_ff;

endmodule

FILE: hdl/alpha_pattern_blend_unit.sv
// Top level of the alpha pattern blend unit: tile memories, blend pipeline, result queue.
//
// Usage:
//   req_* carries one beat per item: tuser is the opcode (load RGB pattern
//   entry, load index pattern entry, blend pixel), tdata the coordinates,
//   alpha and destination pixel. Loads write the pattern entry at the
//   coordinates taken modulo TILE_SIZE and give no result beat. Each
//   blend gives one rsp_* beat; an unused opcode is dropped.
//   csr_* writes the pixel mode (0 indexed, 1 RGB); write it only while idle.
//   One beat is accepted every cycle while req_tready is high; the pipeline
//   never stalls, and an eight-entry result queue takes its output.
//   req_tready drops only when eight blends are in flight or queued, so a
//   stalled receiver holds the input back without losing any result.
//   Reset clears the pipeline, the queue and sets RGB mode. Pattern entries
//   hold nothing until loaded and must be loaded before they are blended.
module alpha_pattern_blend_unit import apb_pkg::*; #(
   parameter int TILE_SIZE = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // tdata: col[15:0], row[31:16], alpha[39:32], dest_red[47:40],
   //        dest_green[55:48], dest_blue[63:56], dest_index[71:64]
   input  logic [71:0]       req_tdata,
   // tuser: opcode[1:0]
   input  logic [OP_W-1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // tdata: out_red[7:0], out_green[15:8], out_blue[23:16], out_index[31:24]
   output logic [OUT_W-1:0]  rsp_tdata,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   localparam int ENTRIES = TILE_SIZE * TILE_SIZE;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam int CRD_W   = $clog2(TILE_SIZE);
   localparam int SUM_W   = 2 * CHAN_W;

   localparam logic [ADDR_W-1:0] SIZE_VEC = ADDR_W'(TILE_SIZE);

   // Mode register.
   logic pixel_mode_in, pixel_mode_ff;

   // Stage 1: registered request.
   logic               s1_valid_in, s1_valid_ff;
   logic [OP_W-1:0]    s1_op_ff;
   logic [COORD_W-1:0] s1_col_ff, s1_row_ff;
   chan_type           s1_alpha_ff, s1_red_ff, s1_green_ff, s1_blue_ff, s1_index_ff;

   // Stages 2 and 3: side data waiting for the coordinate remainders.
   logic               s2_valid_ff, s3_valid_ff;
   logic [OP_W-1:0]    s2_op_ff, s3_op_ff;
   chan_type           s2_alpha_ff, s2_red_ff, s2_green_ff, s2_blue_ff, s2_index_ff;
   chan_type           s3_alpha_ff, s3_red_ff, s3_green_ff, s3_blue_ff, s3_index_ff;
   logic [CRD_W-1:0]   col_mod, row_mod;
   logic [ADDR_W-1:0]  s3_addr;

   // Pattern memories.
   logic [RGB_W-1:0]   rgb_mem [ENTRIES];
   chan_type           index_mem [ENTRIES];

   // Stage 4: pattern read data.
   logic               s4_blend_in, s4_blend_ff;
   logic [RGB_W-1:0]   s4_pat_rgb_ff;
   chan_type           s4_pat_index_ff;
   chan_type           s4_alpha_ff, s4_red_ff, s4_green_ff, s4_blue_ff, s4_index_ff;

   // Stage 5: weighted sums.
   chan_type           inv_alpha;
   logic [SUM_W-1:0]   sum_r_in, sum_g_in, sum_b_in;
   logic [SUM_W-1:0]   s5_sum_r_ff, s5_sum_g_ff, s5_sum_b_ff;
   logic               s5_blend_ff;
   chan_type           s5_index_in, s5_index_ff;

   // Final division by 255 and result word.
   chan_type           div_r, div_g, div_b;
   logic [OUT_W-1:0]   result;

   // Result queue and credit counter.
   logic [OUT_W-1:0]     queue_mem [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_in, wr_ptr_ff, rd_ptr_in, rd_ptr_ff;
   logic [OUT_CNT_W-1:0] fill_in, fill_ff;
   logic [OUT_CNT_W-1:0] credit_in, credit_ff;
   logic                 req_beat, blend_beat, rsp_beat, queue_push;

   function automatic chan_type div255(input logic [SUM_W-1:0] s);
      logic [SUM_W:0] t;
      begin
         t = (SUM_W+1)'(s) + (SUM_W+1)'(s[SUM_W-1:CHAN_W]) + (SUM_W+1)'(1);
         div255 = t[SUM_W-1:CHAN_W];
      end
   endfunction

   // Configuration.
   assign csr_ready     = 1'b1;
   assign pixel_mode_in = (csr_valid && csr_ready) ? csr_data : pixel_mode_ff;

   // Handshakes. Credits count blends from acceptance until their result leaves.
   assign req_tready  = (credit_ff < OUT_CNT_W'(OUT_DEPTH));
   assign req_beat    = req_tvalid && req_tready;
   assign blend_beat  = req_beat && (req_tuser == OP_BLEND);
   assign rsp_beat    = rsp_tvalid && rsp_tready;
   assign queue_push  = s5_blend_ff;
   assign s1_valid_in = req_beat;

   always_comb begin
      credit_in = credit_ff;
      if (blend_beat && !rsp_beat) begin
         credit_in = credit_ff + OUT_CNT_W'(1);
      end else if (!blend_beat && rsp_beat) begin
         credit_in = credit_ff - OUT_CNT_W'(1);
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (queue_push && !rsp_beat) begin
         fill_in = fill_ff + OUT_CNT_W'(1);
      end else if (!queue_push && rsp_beat) begin
         fill_in = fill_ff - OUT_CNT_W'(1);
      end
   end

   assign wr_ptr_in = queue_push ? wr_ptr_ff + OUT_PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = rsp_beat ? rd_ptr_ff + OUT_PTR_W'(1) : rd_ptr_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_mode_ff <= 1'b1;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_blend_ff   <= 1'b0;
         s5_blend_ff   <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fill_ff       <= '0;
         credit_ff     <= '0;
      end else begin
         pixel_mode_ff <= pixel_mode_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         s4_blend_ff   <= s4_blend_in;
         s5_blend_ff   <= s4_blend_ff;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fill_ff       <= fill_in;
         credit_ff     <= credit_in;
      end
   end

   // Stage 1 payload.
   always_ff @(posedge clock) begin
      s1_op_ff    <= req_tuser;
      s1_col_ff   <= req_tdata[15:0];
      s1_row_ff   <= req_tdata[31:16];
      s1_alpha_ff <= req_tdata[39:32];
      s1_red_ff   <= req_tdata[47:40];
      s1_green_ff <= req_tdata[55:48];
      s1_blue_ff  <= req_tdata[63:56];
      s1_index_ff <= req_tdata[71:64];
   end

   apb_mod #(.DIVISOR(TILE_SIZE)) u_col_mod (
      .clock     (clock),
      .value     (s1_col_ff),
      .remainder (col_mod)
   );

   apb_mod #(.DIVISOR(TILE_SIZE)) u_row_mod (
      .clock     (clock),
      .value     (s1_row_ff),
      .remainder (row_mod)
   );

   // Side data follows the two remainder stages.
   always_ff @(posedge clock) begin
      s2_op_ff    <= s1_op_ff;
      s2_alpha_ff <= s1_alpha_ff;
      s2_red_ff   <= s1_red_ff;
      s2_green_ff <= s1_green_ff;
      s2_blue_ff  <= s1_blue_ff;
      s2_index_ff <= s1_index_ff;
      s3_op_ff    <= s2_op_ff;
      s3_alpha_ff <= s2_alpha_ff;
      s3_red_ff   <= s2_red_ff;
      s3_green_ff <= s2_green_ff;
      s3_blue_ff  <= s2_blue_ff;
      s3_index_ff <= s2_index_ff;
   end

   assign s3_addr = ADDR_W'(row_mod) * SIZE_VEC + ADDR_W'(col_mod);

   // Loads and blend reads share one stage, so each beat sees every earlier write.
   always_ff @(posedge clock) begin
      if (s3_valid_ff && (s3_op_ff == OP_LOAD_RGB)) begin
         rgb_mem[s3_addr] <= {s3_red_ff, s3_green_ff, s3_blue_ff};
      end
      if (s3_valid_ff && (s3_op_ff == OP_LOAD_INDEX)) begin
         index_mem[s3_addr] <= s3_index_ff;
      end
      s4_pat_rgb_ff   <= rgb_mem[s3_addr];
      s4_pat_index_ff <= index_mem[s3_addr];
   end

   assign s4_blend_in = s3_valid_ff && (s3_op_ff == OP_BLEND);

   always_ff @(posedge clock) begin
      s4_alpha_ff <= s3_alpha_ff;
      s4_red_ff   <= s3_red_ff;
      s4_green_ff <= s3_green_ff;
      s4_blue_ff  <= s3_blue_ff;
      s4_index_ff <= s3_index_ff;
   end

   // Stage 5: a*p + d*(255-a) per channel; the index choice is settled here too.
   assign inv_alpha = FULL_ALPHA - s4_alpha_ff;
   assign sum_r_in  = SUM_W'(s4_alpha_ff) * SUM_W'(s4_pat_rgb_ff[23:16])
                    + SUM_W'(s4_red_ff) * SUM_W'(inv_alpha);
   assign sum_g_in  = SUM_W'(s4_alpha_ff) * SUM_W'(s4_pat_rgb_ff[15:8])
                    + SUM_W'(s4_green_ff) * SUM_W'(inv_alpha);
   assign sum_b_in  = SUM_W'(s4_alpha_ff) * SUM_W'(s4_pat_rgb_ff[7:0])
                    + SUM_W'(s4_blue_ff) * SUM_W'(inv_alpha);
   assign s5_index_in = (s4_alpha_ff != '0) ? s4_pat_index_ff : s4_index_ff;

   always_ff @(posedge clock) begin
      s5_sum_r_ff <= sum_r_in;
      s5_sum_g_ff <= sum_g_in;
      s5_sum_b_ff <= sum_b_in;
      s5_index_ff <= s5_index_in;
   end

   assign div_r = div255(s5_sum_r_ff);
   assign div_g = div255(s5_sum_g_ff);
   assign div_b = div255(s5_sum_b_ff);

   always_comb begin
      if (pixel_mode_ff) begin
         result = {CHAN_W'(0), div_b, div_g, div_r};
      end else begin
         result = {s5_index_ff, CHAN_W'(0), CHAN_W'(0), CHAN_W'(0)};
      end
   end

   // Result queue.
   always_ff @(posedge clock) begin
      if (queue_push) begin
         queue_mem[wr_ptr_ff] <= result;
      end
   end

   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tdata  = queue_mem[rd_ptr_ff];

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the alpha pattern blend unit: stream stimulus, predictor, scoreboard.
`timescale 1ns / 1ps

module testbench import apb_pkg::*; ();

   localparam int TILE_DIM     = 8;
   localparam int TILE_ENTRIES = TILE_DIM * TILE_DIM;
   localparam int PIPE_LATENCY = 6;
   localparam int STUCK_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 220;
   localparam int PHASE_COUNT  = 6;

   // Opcode 3 has no meaning in the block; it must be dropped silently.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef enum int {
      STALL_NONE,
      STALL_COIN,
      STALL_PERIODIC,
      STALL_LONG
   } stall_style_type;

   // Request beat, col in the lowest bits.
   typedef struct packed {
      chan_type          dest_index;
      chan_type          dest_blue;
      chan_type          dest_green;
      chan_type          dest_red;
      chan_type          alpha;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } pixel_req_type;

   // Result beat, out_red in the lowest bits.
   typedef struct packed {
      chan_type out_index;
      chan_type out_blue;
      chan_type out_green;
      chan_type out_red;
   } blend_pixel_type;

   class blend_scoreboard_type;
      bit               rgb_mode;
      logic [RGB_W-1:0] rgb_tile [TILE_ENTRIES];
      chan_type         idx_tile [TILE_ENTRIES];
      blend_pixel_type  pending_px [$];
      int               errors;
      int               checked;

      function new();
         rgb_mode = 1'b1;
         errors   = 0;
         checked  = 0;
      endfunction

      function int slot_of(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
         return (int'(row) % TILE_DIM) * TILE_DIM + (int'(col) % TILE_DIM);
      endfunction

      function chan_type mix(chan_type a, chan_type p, chan_type d);
         int acc;
         acc = (int'(a) * int'(p) + int'(d) * (int'(FULL_ALPHA) - int'(a)))
               / int'(FULL_ALPHA);
         return chan_type'(acc);
      endfunction

      function void note_request(logic [OP_W-1:0] op, pixel_req_type rq);
         int              s;
         blend_pixel_type px;
         s  = slot_of(rq.col, rq.row);
         px = '0;
         case (op)
            OP_LOAD_RGB: begin
               rgb_tile[s] = {rq.dest_red, rq.dest_green, rq.dest_blue};
            end
            OP_LOAD_INDEX: begin
               idx_tile[s] = rq.dest_index;
            end
            OP_BLEND: begin
               if (rgb_mode) begin
                  px.out_red   = mix(rq.alpha, rgb_tile[s][23:16], rq.dest_red);
                  px.out_green = mix(rq.alpha, rgb_tile[s][15:8], rq.dest_green);
                  px.out_blue  = mix(rq.alpha, rgb_tile[s][7:0], rq.dest_blue);
               end else begin
                  px.out_index = (rq.alpha != 0) ? idx_tile[s] : rq.dest_index;
               end
               pending_px.push_back(px);
            end
            default: begin
            end
         endcase
      endfunction

      function void check_result(blend_pixel_type got);
         blend_pixel_type want;
         if (pending_px.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: result beat with nothing expected: r=%h g=%h b=%h i=%h",
                        $realtime, got.out_red, got.out_green, got.out_blue, got.out_index);
            return;
         end
         want = pending_px.pop_front();
         checked++;
         if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
             got.out_blue !== want.out_blue || got.out_index !== want.out_index) begin
            errors++;
            if (errors <= 10)
               $display("%0t: mismatch, expected r=%h g=%h b=%h i=%h, got r=%h g=%h b=%h i=%h",
                        $realtime, want.out_red, want.out_green, want.out_blue,
                        want.out_index, got.out_red, got.out_green, got.out_blue,
                        got.out_index);
         end
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [71:0]        req_tdata  = '0;
   logic [OP_W-1:0]    req_tuser  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [OUT_W-1:0]   rsp_tdata;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic               csr_data   = 1'b0;

   blend_scoreboard_type sb = new();

   stall_style_type stall_style = STALL_NONE;
   int           stall_left  = 0;
   int           stuck_cycles = 0;
   bit           handshake_seen = 1'b0;
   int           load_beats = 0;
   int           blend_beats = 0;
   int           unused_beats = 0;
   int           mode_writes = 0;

   // Stimulus-side bookkeeping: blends only go to slots loaded in both planes.
   bit rgb_loaded  [TILE_ENTRIES];
   bit idx_loaded  [TILE_ENTRIES];
   bit slot_listed [TILE_ENTRIES];
   int usable_slots [$];

   alpha_pattern_blend_unit #(
      .TILE_SIZE(TILE_DIM)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Handshakes are sampled at the falling edge, where every signal is settled;
   // the beat itself is taken at the following rising edge.
   always @(negedge clock) begin
      handshake_seen = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            handshake_seen = 1'b1;
            sb.note_request(req_tuser, req_tdata);
            if (req_tuser == OP_BLEND)
               blend_beats++;
            else if (req_tuser == OP_UNUSED)
               unused_beats++;
            else
               load_beats++;
         end
         if (rsp_tvalid && rsp_tready) begin
            handshake_seen = 1'b1;
            sb.check_result(rsp_tdata);
         end
         if (csr_valid && csr_ready) begin
            handshake_seen = 1'b1;
            sb.rgb_mode = csr_data;
            mode_writes++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || handshake_seen) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles == STUCK_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles.", STUCK_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Receiver back-pressure, shaped per phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         case (stall_style)
            STALL_NONE: begin
               rsp_tready <= 1'b1;
            end
            STALL_COIN: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            STALL_PERIODIC: begin
               rsp_tready <= !rsp_tready;
               stall_left <= 2;
            end
            default: begin
               rsp_tready <= !rsp_tready;
               stall_left <= rsp_tready ? int'($urandom_range(5, 30))
                                        : int'($urandom_range(0, 10));
            end
         endcase
      end
   end

   function automatic logic [COORD_W-1:0] rand_coord();
      return COORD_W'($urandom_range(0, 65535));
   endfunction

   function automatic chan_type rand_chan();
      return chan_type'($urandom_range(0, 255));
   endfunction

   task automatic send_beat(logic [OP_W-1:0] op, logic [COORD_W-1:0] col,
                            logic [COORD_W-1:0] row, chan_type alpha, chan_type red,
                            chan_type green, chan_type blue, chan_type index_val);
      pixel_req_type rq;
      int            s;
      rq.col        = col;
      rq.row        = row;
      rq.alpha      = alpha;
      rq.dest_red   = red;
      rq.dest_green = green;
      rq.dest_blue  = blue;
      rq.dest_index = index_val;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= rq;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      s = sb.slot_of(col, row);
      if (op == OP_LOAD_RGB)
         rgb_loaded[s] = 1'b1;
      else if (op == OP_LOAD_INDEX)
         idx_loaded[s] = 1'b1;
      if (rgb_loaded[s] && idx_loaded[s] && !slot_listed[s]) begin
         slot_listed[s] = 1'b1;
         usable_slots.push_back(s);
      end
   endtask

   // Loads give no result beat, so after the last result the pipeline may still
   // hold loads; an extra wait after the last result lets them land.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending_px.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_mode(bit rgb);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= rgb;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic chan_type pick_alpha();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         return '0;
      else if (sel == 1)
         return FULL_ALPHA;
      return chan_type'($urandom_range(0, 255));
   endfunction

   task automatic send_random_item(output bit counted);
      int                 pick;
      int                 s;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      pick    = $urandom_range(0, 99);
      counted = 1'b1;
      if (usable_slots.size() == 0)
         pick = $urandom_range(6, 41);
      if (pick < 6) begin
         counted = 1'b0;
         send_beat(OP_UNUSED, rand_coord(), rand_coord(), rand_chan(), rand_chan(),
                   rand_chan(), rand_chan(), rand_chan());
      end else if (pick < 28) begin
         send_beat(OP_LOAD_RGB, rand_coord(), rand_coord(), rand_chan(), rand_chan(),
                   rand_chan(), rand_chan(), rand_chan());
      end else if (pick < 42) begin
         send_beat(OP_LOAD_INDEX, rand_coord(), rand_coord(), rand_chan(), rand_chan(),
                   rand_chan(), rand_chan(), rand_chan());
      end else begin
         // Any coordinate that wraps onto a loaded slot is fair game.
         s   = usable_slots[$urandom_range(0, usable_slots.size() - 1)];
         col = COORD_W'($urandom_range(0, 65535 / TILE_DIM) * TILE_DIM + s % TILE_DIM);
         row = COORD_W'($urandom_range(0, 65535 / TILE_DIM) * TILE_DIM + s / TILE_DIM);
         send_beat(OP_BLEND, col, row, pick_alpha(), rand_chan(),
                   rand_chan(), rand_chan(), rand_chan());
      end
   endtask

   initial begin
      int phase;
      int n;
      int burst_left;
      bit counted;
      bit steady;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes, wrapped coordinates, both modes, the unused opcode.
      write_mode(1'b1);
      send_beat(OP_LOAD_RGB, 16'd0, 16'd0, 8'h00, 8'hff, 8'hff, 8'hff, 8'h00);
      send_beat(OP_LOAD_INDEX, 16'd0, 16'd0, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff);
      send_beat(OP_LOAD_RGB, 16'hffff, 16'hffff, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff);
      send_beat(OP_LOAD_INDEX, 16'hffff, 16'hffff, 8'h00, 8'hff, 8'hff, 8'hff, 8'h00);
      send_beat(OP_LOAD_RGB, 16'd9, 16'd17, 8'h12, 8'ha5, 8'h5a, 8'h3c, 8'h00);
      send_beat(OP_LOAD_INDEX, 16'd9, 16'd17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5a);
      send_beat(OP_BLEND, 16'd0, 16'd0, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
      send_beat(OP_BLEND, 16'd8, 16'd8, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff);
      send_beat(OP_BLEND, 16'hffff, 16'hffff, 8'h80, 8'hff, 8'hff, 8'hff, 8'h11);
      send_beat(OP_BLEND, 16'd1, 16'd65529, 8'h01, 8'h80, 8'h7f, 8'h01, 8'h22);
      send_beat(OP_UNUSED, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
      send_beat(OP_BLEND, 16'd0, 16'd0, 8'hfe, 8'h37, 8'hc8, 8'h6e, 8'h44);
      write_mode(1'b0);
      send_beat(OP_BLEND, 16'd0, 16'd0, 8'h00, 8'h10, 8'h20, 8'h30, 8'h33);
      send_beat(OP_BLEND, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
      send_beat(OP_BLEND, 16'd9, 16'd17, 8'h01, 8'h00, 8'h00, 8'h00, 8'hc3);
      send_beat(OP_UNUSED, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_beat(OP_LOAD_INDEX, 16'd16, 16'd24, 8'h00, 8'h00, 8'h00, 8'h00, 8'h81);
      send_beat(OP_BLEND, 16'd0, 16'd0, 8'hc8, 8'h00, 8'h00, 8'h00, 8'h7e);

      // Random part: modes alternate, back-pressure style and sender gaps vary by phase.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         write_mode(phase % 2 == 0);
         stall_style = stall_style_type'(phase % 4);
         steady      = (phase == 3);
         n           = 0;
         burst_left  = $urandom_range(1, 40);
         while (n < PHASE_ITEMS) begin
            send_random_item(counted);
            if (counted)
               n++;
            burst_left--;
            if (!steady && burst_left == 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
               burst_left = $urandom_range(1, 40);
            end
         end
      end

      wait_drained();
      $display("Run covered %0d load beats, %0d blend beats and %0d dropped beats,",
               load_beats, blend_beats, unused_beats);
      $display("over %0d mode writes; %0d result beats checked, %0d mismatches.",
               mode_writes, sb.checked, sb.errors);
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: files.f
hdl/apb_pkg.sv
hdl/apb_mod.sv
hdl/alpha_pattern_blend_unit.sv
tb/sv/testbench.sv
